// ===== rtl/core/circular_list_with_cursor_top_assert.svh =====
// Assertion macros shared by the list core. Each macro expects clk and rst_n in scope.
`ifndef CIRCULAR_LIST_WITH_CURSOR_TOP_ASSERT_SVH
`define CIRCULAR_LIST_WITH_CURSOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define CLC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define CLC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define CLC_ASSERT(lbl, cond, msg)

`define CLC_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== rtl/core/clc_pkg.sv =====
package clc_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int KIND_W = 3;
    localparam int WORD_W = 32;
    localparam int ELEM_W = 7;

    localparam logic [KIND_W-1:0] K_INS_HEAD = 3'd0;
    localparam logic [KIND_W-1:0] K_INS_TAIL = 3'd1;
    localparam logic [KIND_W-1:0] K_FIRST    = 3'd2;
    localparam logic [KIND_W-1:0] K_NEXT     = 3'd3;
    localparam logic [KIND_W-1:0] K_REMOVE   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOCUR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_LINK,
        S_INS_TAIL,
        S_LOOK_LINK,
        S_LOOK_VAL,
        S_RM_READ,
        S_RM_WALK
    } seq_state_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [WORD_W-1:0] value_out;
        logic [ELEM_W-1:0] elements;
    } res_t;

    // Requests from the sequencer to the free-node stack.
    typedef struct packed {
        logic             look;
        logic             pop;
        logic             push;
        logic [IDX_W-1:0] push_idx;
    } fs_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0] top;
        logic [IDX_W-1:0] pop_idx;
    } fs_stat_t;

    function automatic logic [VALUE_WIDTH-1:0] from_word(input logic [WORD_W-1:0] w);
        logic [VALUE_WIDTH+WORD_W-1:0] ext;
        ext = {{VALUE_WIDTH{1'b0}}, w};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] to_word(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH+WORD_W-1:0] ext;
        ext = {{WORD_W{1'b0}}, v};
        return ext[WORD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/clc_stream_if.sv =====
interface clc_cmd_if;
    import clc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink (input valid, kind, value, output ready);
endinterface

interface clc_rsp_if;
    import clc_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [WORD_W-1:0] value_out;
    logic [ELEM_W-1:0] elements;

    modport source (output valid, status, value_out, elements, input ready);
    modport sink (input valid, status, value_out, elements, output ready);
endinterface

// ===== rtl/core/circular_list_with_cursor_top.sv =====
// Circular singly linked list of up to CAPACITY words held in node memories, with a tail
// pointer, a read cursor and an element count; each command beat yields one response
// beat with a status, a data word and the element count after the command. Rejected
// commands (full pool, empty list, no valid cursor) and unknown kinds are answered from
// idle without a memory access. An insert reads the tail link and the free stack, then
// makes two writes through the single write port of the link memory; an insert into an
// empty list needs only the first write. Cursor to first and cursor next do a link read
// followed by a value read of the node it names. Removing the only element needs only
// the read of the cursor node; any other remove then walks the links from the tail to
// the predecessor of the cursor node, one link read per cycle. The response beat is
// offered from an output register; a result that finds that register still held waits
// in a pending register. No clearing pass follows reset. A new command is taken while
// one response still waits downstream, thanks to a two-entry response buffer.
`include "circular_list_with_cursor_top_assert.svh"

module circular_list_with_cursor_top (
    input logic       clk,
    input logic       rst_n,
    clc_cmd_if.sink   cmd,
    clc_rsp_if.source rsp
);
    import clc_pkg::*;

    fs_ctl_t  fs_ctl;
    fs_stat_t fs_stat;
    res_t     res;
    logic     seq_idle;
    logic     accept;

    logic     out_valid_reg;
    res_t     out_reg;
    logic     pend_reg;
    res_t     pend_data_reg;
    logic     slot_free;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign cmd.ready = seq_idle && (!pend_reg || slot_free);
    assign accept    = cmd.valid && cmd.ready;

    clc_free u_free (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (fs_ctl),
        .stat (fs_stat)
    );

    clc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (cmd.kind),
        .value  (cmd.value),
        .fs_stat(fs_stat),
        .fs_ctl (fs_ctl),
        .res    (res),
        .idle   (seq_idle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (slot_free)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= res.valid;
            end
            else
            begin
                out_valid_reg <= res.valid;
            end
        end
        else if (res.valid)
        begin
            pend_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (pend_reg)
            begin
                out_reg       <= pend_data_reg;
                pend_data_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (res.valid)
        begin
            pend_data_reg <= res;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_reg.status;
    assign rsp.value_out = out_reg.value_out;
    assign rsp.elements  = out_reg.elements;

    `CLC_ASSERT(a_busy_no_pend, seq_idle || !pend_reg, "response held while a command is in work")
    `CLC_ASSERT(a_no_overrun, !(res.valid && pend_reg && !slot_free), "response buffer overrun")

endmodule

// ===== rtl/core/clc_ram.sv =====
module clc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/clc_free.sv =====
module clc_free (
    input  logic              clk,
    input  logic              rst_n,
    input  clc_pkg::fs_ctl_t  ctl,
    output clc_pkg::fs_stat_t stat
);
    import clc_pkg::*;

    logic [CNT_W-1:0] top_reg;
    logic [CNT_W-1:0] mark_reg;
    logic             fresh_reg;
    logic [IDX_W-1:0] fresh_idx_reg;
    logic [CNT_W-1:0] top_m1;
    logic [CNT_W-1:0] fresh_full;
    logic [IDX_W-1:0] ram_rdata;

    // Stack slots below the lowest top ever reached were never pushed, so their contents are
    // not read from the memory but follow from the slot position alone.
    assign top_m1     = top_reg - CNT_W'(1);
    assign fresh_full = CNT_W'(CAPACITY) - top_reg;

    clc_ram #(
        .WIDTH(IDX_W),
        .DEPTH(CAPACITY)
    ) u_stack (
        .clk  (clk),
        .we   (ctl.push),
        .waddr(top_reg[IDX_W-1:0]),
        .wdata(ctl.push_idx),
        .re   (ctl.look),
        .raddr(top_m1[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= CNT_W'(CAPACITY);
            mark_reg  <= CNT_W'(CAPACITY);
            fresh_reg <= 1'b0;
        end
        else
        begin
            if (ctl.look)
            begin
                fresh_reg <= (top_reg == mark_reg);
            end
            if (ctl.pop)
            begin
                top_reg <= top_m1;
                if (top_reg == mark_reg)
                begin
                    mark_reg <= top_m1;
                end
            end
            else if (ctl.push)
            begin
                top_reg <= top_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.look)
        begin
            fresh_idx_reg <= fresh_full[IDX_W-1:0];
        end
    end

    assign stat.top     = top_reg;
    assign stat.pop_idx = fresh_reg ? fresh_idx_reg : ram_rdata;

endmodule

// ===== rtl/core/clc_seq.sv =====
`include "circular_list_with_cursor_top_assert.svh"

module clc_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [clc_pkg::KIND_W-1:0] kind,
    input  logic [clc_pkg::WORD_W-1:0] value,
    input  clc_pkg::fs_stat_t          fs_stat,
    output clc_pkg::fs_ctl_t           fs_ctl,
    output clc_pkg::res_t              res,
    output logic                       idle
);
    import clc_pkg::*;

    seq_state_t             state_reg, state_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic                   cvalid_reg, cvalid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   at_tail_reg, at_tail_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       pred_reg, pred_next;
    logic [IDX_W-1:0]       vlink_reg, vlink_next;
    logic [VALUE_WIDTH-1:0] data_reg, data_next;
    logic [CNT_W-1:0]       steps_reg, steps_next;

    logic                   lk_we, lk_re;
    logic [IDX_W-1:0]       lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic                   vl_we, vl_re;
    logic [IDX_W-1:0]       vl_waddr, vl_raddr;
    logic [VALUE_WIDTH-1:0] vl_wdata, vl_rdata;

    logic                   list_empty;
    logic                   pool_full;

    clc_ram #(
        .WIDTH(IDX_W),
        .DEPTH(CAPACITY)
    ) u_link (
        .clk  (clk),
        .we   (lk_we),
        .waddr(lk_waddr),
        .wdata(lk_wdata),
        .re   (lk_re),
        .raddr(lk_raddr),
        .rdata(lk_rdata)
    );

    clc_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(CAPACITY)
    ) u_value (
        .clk  (clk),
        .we   (vl_we),
        .waddr(vl_waddr),
        .wdata(vl_wdata),
        .re   (vl_re),
        .raddr(vl_raddr),
        .rdata(vl_rdata)
    );

    assign list_empty = (count_reg == '0);
    assign pool_full  = (fs_stat.top == '0) || (count_reg >= CNT_W'(CAPACITY));
    assign idle       = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tail_reg   <= '0;
            cursor_reg <= '0;
            cvalid_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
            cvalid_reg <= cvalid_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_tail_reg <= at_tail_next;
        val_reg     <= val_next;
        n_reg       <= n_next;
        pred_reg    <= pred_next;
        vlink_reg   <= vlink_next;
        data_reg    <= data_next;
        steps_reg   <= steps_next;
    end

    // Every node memory write lands before the next read of the same entry, since each
    // item finishes its writes before the sequencer returns to idle.
    always_comb
    begin
        state_next   = state_reg;
        tail_next    = tail_reg;
        cursor_next  = cursor_reg;
        cvalid_next  = cvalid_reg;
        count_next   = count_reg;
        at_tail_next = at_tail_reg;
        val_next     = val_reg;
        n_next       = n_reg;
        pred_next    = pred_reg;
        vlink_next   = vlink_reg;
        data_next    = data_reg;
        steps_next   = steps_reg;

        lk_we    = 1'b0;
        lk_waddr = '0;
        lk_wdata = '0;
        lk_re    = 1'b0;
        lk_raddr = '0;
        vl_we    = 1'b0;
        vl_waddr = '0;
        vl_wdata = '0;
        vl_re    = 1'b0;
        vl_raddr = '0;
        fs_ctl   = '0;
        res      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind) inside
                        K_INS_HEAD, K_INS_TAIL:
                        begin
                            if (pool_full)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                at_tail_next = (kind == K_INS_TAIL);
                                val_next     = from_word(value);
                                fs_ctl.look  = 1'b1;
                                lk_re        = 1'b1;
                                lk_raddr     = tail_reg;
                                state_next   = S_INS_LINK;
                            end
                        end
                        K_FIRST:
                        begin
                            if (list_empty)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                lk_re      = 1'b1;
                                lk_raddr   = tail_reg;
                                state_next = S_LOOK_LINK;
                            end
                        end
                        K_NEXT:
                        begin
                            if (list_empty)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else if (!cvalid_reg)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_NOCUR;
                            end
                            else
                            begin
                                lk_re      = 1'b1;
                                lk_raddr   = cursor_reg;
                                state_next = S_LOOK_LINK;
                            end
                        end
                        K_REMOVE:
                        begin
                            if (list_empty)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else if (!cvalid_reg)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_NOCUR;
                            end
                            else
                            begin
                                lk_re      = 1'b1;
                                lk_raddr   = cursor_reg;
                                vl_re      = 1'b1;
                                vl_raddr   = cursor_reg;
                                state_next = S_RM_READ;
                            end
                        end
                        default:
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_LINK:
            begin
                n_next     = fs_stat.pop_idx;
                fs_ctl.pop = 1'b1;
                vl_we      = 1'b1;
                vl_waddr   = fs_stat.pop_idx;
                vl_wdata   = val_reg;
                lk_we      = 1'b1;
                lk_waddr   = fs_stat.pop_idx;
                lk_wdata   = list_empty ? fs_stat.pop_idx : lk_rdata;
                if (list_empty)
                begin
                    tail_next  = fs_stat.pop_idx;
                    count_next = count_reg + CNT_W'(1);
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_INS_TAIL;
                end
            end
            S_INS_TAIL:
            begin
                lk_we    = 1'b1;
                lk_waddr = tail_reg;
                lk_wdata = n_reg;
                if (at_tail_reg)
                begin
                    tail_next = n_reg;
                end
                count_next = count_reg + CNT_W'(1);
                res.valid  = 1'b1;
                state_next = S_IDLE;
            end
            S_LOOK_LINK:
            begin
                cursor_next = lk_rdata;
                cvalid_next = 1'b1;
                vl_re       = 1'b1;
                vl_raddr    = lk_rdata;
                state_next  = S_LOOK_VAL;
            end
            S_LOOK_VAL:
            begin
                res.valid     = 1'b1;
                res.value_out = to_word(vl_rdata);
                state_next    = S_IDLE;
            end
            S_RM_READ:
            begin
                data_next  = vl_rdata;
                vlink_next = lk_rdata;
                if (count_reg == CNT_W'(1))
                begin
                    cvalid_next     = 1'b0;
                    cursor_next     = '0;
                    tail_next       = '0;
                    fs_ctl.push     = 1'b1;
                    fs_ctl.push_idx = cursor_reg;
                    count_next      = count_reg - CNT_W'(1);
                    res.valid       = 1'b1;
                    res.value_out   = to_word(vl_rdata);
                    state_next      = S_IDLE;
                end
                else
                begin
                    lk_re      = 1'b1;
                    lk_raddr   = tail_reg;
                    pred_next  = tail_reg;
                    steps_next = '0;
                    state_next = S_RM_WALK;
                end
            end
            S_RM_WALK:
            begin
                // The link of the current candidate arrives here; stop when it points
                // at the node being removed or after a full lap of the pool.
                if ((lk_rdata == cursor_reg) || (steps_reg == CNT_W'(CAPACITY)))
                begin
                    lk_we    = 1'b1;
                    lk_waddr = pred_reg;
                    lk_wdata = vlink_reg;
                    if (cursor_reg == tail_reg)
                    begin
                        tail_next = pred_reg;
                    end
                    cursor_next     = pred_reg;
                    fs_ctl.push     = 1'b1;
                    fs_ctl.push_idx = cursor_reg;
                    count_next      = count_reg - CNT_W'(1);
                    res.valid       = 1'b1;
                    res.value_out   = to_word(data_reg);
                    state_next      = S_IDLE;
                end
                else
                begin
                    pred_next  = lk_rdata;
                    steps_next = steps_reg + CNT_W'(1);
                    lk_re      = 1'b1;
                    lk_raddr   = lk_rdata;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.elements = ELEM_W'(count_next);
    end

    `CLC_ASSERT(a_cursor_needs_list, !cvalid_reg || (count_reg != '0), "cursor valid on empty list")
    `CLC_ASSERT(a_pool_balance, !idle || (count_reg == CNT_W'(CAPACITY) - fs_stat.top), "pool count mismatch")
    `CLC_ASSERT_NEXT(a_walk_ends_idle, res.valid, state_reg == S_IDLE, "result not followed by idle")

endmodule

// ===== bench/circular_list_with_cursor_top_tb.sv =====
module circular_list_with_cursor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clc_pkg::*;

    localparam logic [KIND_W-1:0] K_UNUSED_5 = 3'd5;
    localparam logic [KIND_W-1:0] K_UNUSED_6 = 3'd6;
    localparam logic [KIND_W-1:0] K_UNUSED_7 = 3'd7;

    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIX   = 2;

    localparam int DIR_ROWS      = 25;
    localparam int RAND_OPS      = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 400;
    localparam int DRAIN_CYCLES  = 100;
    localparam int MAX_REPORTS   = 10;
    localparam int LIMIT_NS      = 3_000_000;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] value_out;
        logic [ELEM_W-1:0] elements;
    } list_rsp_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] value;
        logic              fixed;
        list_rsp_t         rsp;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    clc_cmd_if cmd_ch ();
    clc_rsp_if rsp_ch ();

    circular_list_with_cursor_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the list, updated once per accepted command beat.
    logic [WORD_W-1:0] ring_val  [CAPACITY];
    logic [IDX_W-1:0]  ring_link [CAPACITY];
    logic [IDX_W-1:0]  free_idx  [CAPACITY];
    logic [CNT_W-1:0]  free_cnt;
    logic [IDX_W-1:0]  tail_idx;
    logic [IDX_W-1:0]  cur_idx;
    logic              cur_ok;
    logic [CNT_W-1:0]  elem_cnt;

    list_rsp_t pending_rsp_q [$];
    int        mismatch_cnt = 0;
    int        cmds_taken = 0;

    step_row_t dir_rows [DIR_ROWS] = '{
        '{K_FIRST,    32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 7'd0}},
        '{K_NEXT,     32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 32'h0000_0000, 7'd0}},
        '{K_REMOVE,   32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 7'd0}},
        '{K_UNUSED_5, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_UNUSED_6, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_UNUSED_7, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_INS_HEAD, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0000_0000, 7'd1}},
        '{K_NEXT,     32'h0000_0000, 1'b1, '{ST_NOCUR, 32'h0000_0000, 7'd1}},
        '{K_REMOVE,   32'h0000_0000, 1'b1, '{ST_NOCUR, 32'h0000_0000, 7'd1}},
        '{K_FIRST,    32'h0000_0000, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 7'd1}},
        '{K_NEXT,     32'h0000_0000, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 7'd1}},
        '{K_REMOVE,   32'h0000_0000, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 7'd0}},
        '{K_NEXT,     32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 7'd0}},
        '{K_INS_TAIL, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 7'd1}},
        '{K_INS_TAIL, 32'h5555_5555, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_INS_HEAD, 32'hAAAA_AAAA, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_NEXT,     32'h0000_0000, 1'b1, '{ST_NOCUR, 32'h0000_0000, 7'd3}},
        '{K_FIRST,    32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_NEXT,     32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_NEXT,     32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_REMOVE,   32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_NEXT,     32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_INS_HEAD, 32'h1234_5678, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_REMOVE,   32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}},
        '{K_REMOVE,   32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 7'd0}}
    };

    function automatic void clear_ring();
        for (int i = 0; i < CAPACITY; i++)
        begin
            ring_val[i]  = '0;
            ring_link[i] = '0;
            free_idx[i]  = IDX_W'(CAPACITY - 1 - i);
        end
        free_cnt = CNT_W'(CAPACITY);
        tail_idx = '0;
        cur_idx  = '0;
        cur_ok   = 1'b0;
        elem_cnt = '0;
    endfunction

    function automatic list_rsp_t apply_list_op(input logic [KIND_W-1:0] kind,
                                                input logic [WORD_W-1:0] value);
        list_rsp_t        r;
        logic [IDX_W-1:0] node;
        logic [IDX_W-1:0] pred;
        int               steps;
        r.status    = ST_OK;
        r.value_out = '0;
        case (kind)
            K_INS_HEAD, K_INS_TAIL:
            begin
                if (free_cnt == 0 || elem_cnt >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    free_cnt = free_cnt - 1'b1;
                    node = free_idx[free_cnt[IDX_W-1:0]];
                    ring_val[node] = value;
                    if (elem_cnt == 0)
                    begin
                        ring_link[node] = node;
                        tail_idx = node;
                    end
                    else
                    begin
                        ring_link[node] = ring_link[tail_idx];
                        ring_link[tail_idx] = node;
                        if (kind == K_INS_TAIL)
                        begin
                            tail_idx = node;
                        end
                    end
                    elem_cnt = elem_cnt + 1'b1;
                end
            end
            K_FIRST:
            begin
                if (elem_cnt == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    cur_idx = ring_link[tail_idx];
                    cur_ok = 1'b1;
                    r.value_out = ring_val[cur_idx];
                end
            end
            K_NEXT:
            begin
                if (elem_cnt == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (!cur_ok)
                begin
                    r.status = ST_NOCUR;
                end
                else
                begin
                    cur_idx = ring_link[cur_idx];
                    r.value_out = ring_val[cur_idx];
                end
            end
            K_REMOVE:
            begin
                if (elem_cnt == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (!cur_ok)
                begin
                    r.status = ST_NOCUR;
                end
                else
                begin
                    node = cur_idx;
                    r.value_out = ring_val[node];
                    if (elem_cnt == 1)
                    begin
                        cur_ok = 1'b0;
                        cur_idx = '0;
                        tail_idx = '0;
                    end
                    else
                    begin
                        // Walk from the tail to the node that links to the cursor.
                        pred = tail_idx;
                        steps = 0;
                        while (ring_link[pred] != node && steps < CAPACITY)
                        begin
                            pred = ring_link[pred];
                            steps++;
                        end
                        if (node == tail_idx)
                        begin
                            tail_idx = pred;
                        end
                        ring_link[pred] = ring_link[node];
                        cur_idx = pred;
                    end
                    free_idx[free_cnt[IDX_W-1:0]] = node;
                    free_cnt = free_cnt + 1'b1;
                    elem_cnt = elem_cnt - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.elements = ELEM_W'(elem_cnt);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            return 0;
        end
        else if (pick < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return '0;
        end
        else if (pick == 1)
        begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input int phase);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (phase == PH_FILL)
        begin
            if (pick < 80)
            begin
                return pick[0] ? K_INS_TAIL : K_INS_HEAD;
            end
            return (pick < 88) ? K_FIRST : K_NEXT;
        end
        else if (phase == PH_DRAIN)
        begin
            if (pick < 70)
            begin
                return K_REMOVE;
            end
            else if (pick < 85)
            begin
                return K_NEXT;
            end
            else if (pick < 95)
            begin
                return K_FIRST;
            end
            return KIND_W'($urandom_range(0, 7));
        end
        return KIND_W'($urandom_range(0, 7));
    endfunction

    task automatic issue_cmd(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                             input logic fixed, input list_rsp_t fixed_rsp);
        list_rsp_t   want;
        int unsigned gap;
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind  <= kind;
        cmd_ch.value <= value;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        want = apply_list_op(kind, value);
        pending_rsp_q.push_back(fixed ? fixed_rsp : want);
        cmds_taken++;
        // The valid stays high into the next beat when there is no gap.
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    initial
    begin : cmd_drive
        int                rand_ops;
        int                phase;
        int unsigned       len;
        logic [KIND_W-1:0] kind;
        rand_ops = 0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.kind  <= K_INS_HEAD;
        cmd_ch.value <= '0;
        clear_ring();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            issue_cmd(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].rsp);
        end

        while (rand_ops < RAND_OPS)
        begin
            phase = $urandom_range(PH_FILL, PH_MIX);
            len = $urandom_range(30, 100);
            if (phase == PH_DRAIN)
            begin
                issue_cmd(K_FIRST, pick_value(), 1'b0, '0);
                rand_ops++;
            end
            repeat (len)
            begin
                kind = pick_kind(phase);
                issue_cmd(kind, pick_value(), 1'b0, '0);
                if (kind <= K_REMOVE)
                begin
                    rand_ops++;
                end
            end
        end
        cmd_ch.valid <= 1'b0;

        while (pending_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_rsp_q.size() == 0)
        begin
            $display("circular_list_with_cursor_top regression: pass");
        end
        else
        begin
            $display("circular_list_with_cursor_top regression: fail");
        end
        $finish;
    end

    initial
    begin : rsp_ready_drive
        int unsigned span;
        int unsigned pick;
        logic        held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && cmds_taken >= HOLD_AFTER)
            begin
                // One long hold-off so the response buffer fills and the input stalls.
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    rsp_ch.ready <= 1'b1;
                    span = $urandom_range(1, 40);
                end
                else if (pick < 93)
                begin
                    rsp_ch.ready <= 1'b0;
                    span = $urandom_range(1, 3);
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    span = $urandom_range(12, 50);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    initial
    begin : rsp_check
        list_rsp_t want;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp_q.size() == 0)
                begin
                    report_mismatch($sformatf("response beat with nothing pending: %0d %h %0d",
                        rsp_ch.status, rsp_ch.value_out, rsp_ch.elements));
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.value_out !== want.value_out
                        || rsp_ch.elements !== want.elements)
                    begin
                        report_mismatch($sformatf(
                            "response mismatch: expected %0d %h %0d, got %0d %h %0d",
                            want.status, want.value_out, want.elements,
                            rsp_ch.status, rsp_ch.value_out, rsp_ch.elements));
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("circular_list_with_cursor_top regression: fail");
        $finish;
    end

endmodule
